>>> hdl/two_stack_queue_assert.svh
// assertion macros used by the queue checker
`ifndef TWO_STACK_QUEUE_ASSERT_SVH
`define TWO_STACK_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define TSQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_stack_queue: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define TSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_stack_queue: next-cycle check failed");

`endif

>>> hdl/tsq_pkg.sv
// package of the two-stack queue: beat types, status codes, controller states
package tsq_pkg;

    // default stack depth in words
    localparam int DEPTH_DEFAULT = 16;

    // data word width
    localparam int WORD_W = 32;

    // operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } tsq_status_t;

    // command beat
    typedef struct packed {
        logic                     mode;
        logic signed [WORD_W-1:0] enqueue_value;
    } tsq_cmd_t;

    // result beat
    typedef struct packed {
        tsq_status_t              status;
        logic signed [WORD_W-1:0] dequeued_value;
        logic                     now_empty;
    } tsq_rsp_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XFER,
        ST_XDRAIN,
        ST_POP
    } tsq_state_t;

endpackage

>>> hdl/two_stack_queue.sv
// first-in first-out queue built from an inbox stack and an outbox stack in memories
//
//  channel   ports                 beat      handshake
//  command   start, busy, cmd      tsq_cmd_t taken when start && !busy
//  result    strobe, result        tsq_rsp_t one cycle, taken when strobe
//
// an enqueue with room, a full refusal and an empty refusal are answered straight from idle;
// a dequeue from a non-empty outbox answers from the pop state (one outbox read port access).
// moving the inbox across keeps busy high through the transfer and drain states for n held
// words: n inbox reads, each word written to the outbox in the cycle after its read; the
// pending operation finishes in the drain state, which registers its result beat.
// reset clears both word counts; the stack memories hold no reset state.
// results cannot be stalled; busy is high while a move or a pop is in flight.
module two_stack_queue #(
    parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tsq_pkg::tsq_cmd_t cmd,
    output logic             strobe,
    output tsq_pkg::tsq_rsp_t result
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_ZERO = '0;

    // stack memories
    logic [tsq_pkg::WORD_W-1:0] inbox_mem  [DEPTH];
    logic [tsq_pkg::WORD_W-1:0] outbox_mem [DEPTH];

    // control state
    tsq_pkg::tsq_state_t state_reg, state_next;
    logic [CW-1:0]       in_cnt_reg, in_cnt_next;
    logic [CW-1:0]       out_cnt_reg, out_cnt_next;
    logic [CW-1:0]       xfer_cnt_reg, xfer_cnt_next;
    logic                wr_vld_reg, wr_vld_next;
    logic                strobe_reg, strobe_next;

    // payload state
    tsq_pkg::tsq_cmd_t          cmd_reg, cmd_next;
    tsq_pkg::tsq_rsp_t          rsp_reg, rsp_next;
    logic [IDX_W-1:0]           wr_addr_reg, wr_addr_next;
    logic [tsq_pkg::WORD_W-1:0] in_rdata_reg;
    logic [tsq_pkg::WORD_W-1:0] out_rdata_reg;

    // memory port controls
    logic                       in_we;
    logic [IDX_W-1:0]           in_waddr;
    logic [tsq_pkg::WORD_W-1:0] in_wdata;
    logic [IDX_W-1:0]           in_raddr;
    logic [IDX_W-1:0]           out_raddr;
    logic [CW-1:0]              in_rd_pos;
    logic [CW-1:0]              out_top;
    logic                       accept;

    assign accept = start && (state_reg == tsq_pkg::ST_IDLE);

    // read addresses: inbox walked from the top down, outbox at its top word
    assign in_rd_pos = in_cnt_reg - CNT_ONE - xfer_cnt_reg;
    assign in_raddr  = in_rd_pos[IDX_W-1:0];
    assign out_top   = out_cnt_reg - CNT_ONE;
    assign out_raddr = out_top[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == tsq_pkg::MODE_ENQ)
                    begin
                        if (in_cnt_reg == CNT_FULL && out_cnt_reg == CNT_ZERO)
                            state_next = tsq_pkg::ST_XFER;
                    end
                    else if (out_cnt_reg != CNT_ZERO)
                        state_next = tsq_pkg::ST_POP;
                    else if (in_cnt_reg != CNT_ZERO)
                        state_next = tsq_pkg::ST_XFER;
                end
            end
            tsq_pkg::ST_XFER:
            begin
                if (xfer_cnt_reg == in_cnt_reg - CNT_ONE)
                    state_next = tsq_pkg::ST_XDRAIN;
            end
            tsq_pkg::ST_XDRAIN: state_next = tsq_pkg::ST_IDLE;
            tsq_pkg::ST_POP:    state_next = tsq_pkg::ST_IDLE;
            default:            state_next = tsq_pkg::ST_IDLE;
        endcase
    end

    // counts, memory controls and result beat
    always_comb
    begin
        in_cnt_next   = in_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        xfer_cnt_next = xfer_cnt_reg;
        wr_vld_next   = 1'b0;
        wr_addr_next  = wr_addr_reg;
        strobe_next   = 1'b0;
        cmd_next      = cmd_reg;
        rsp_next      = rsp_reg;
        in_we         = 1'b0;
        in_waddr      = in_cnt_reg[IDX_W-1:0];
        in_wdata      = cmd.enqueue_value;
        case (state_reg)
            tsq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next                = cmd;
                    xfer_cnt_next           = CNT_ZERO;
                    rsp_next.dequeued_value = '0;
                    rsp_next.status         = tsq_pkg::STATUS_OK;
                    rsp_next.now_empty      = 1'b0;
                    if (cmd.mode == tsq_pkg::MODE_ENQ)
                    begin
                        if (in_cnt_reg != CNT_FULL)
                        begin
                            // push onto the inbox
                            in_we       = 1'b1;
                            in_cnt_next = in_cnt_reg + CNT_ONE;
                            strobe_next = 1'b1;
                        end
                        else if (out_cnt_reg != CNT_ZERO)
                        begin
                            rsp_next.status = tsq_pkg::STATUS_FULL;
                            strobe_next     = 1'b1;
                        end
                    end
                    else if (out_cnt_reg != CNT_ZERO)
                    begin
                        // pop issued, data lands next cycle
                        out_cnt_next = out_top;
                    end
                    else if (in_cnt_reg == CNT_ZERO)
                    begin
                        rsp_next.status    = tsq_pkg::STATUS_EMPTY;
                        rsp_next.now_empty = 1'b1;
                        strobe_next        = 1'b1;
                    end
                end
            end
            tsq_pkg::ST_XFER:
            begin
                // read one inbox word, write it to the outbox in the next cycle
                wr_vld_next   = 1'b1;
                wr_addr_next  = xfer_cnt_reg[IDX_W-1:0];
                xfer_cnt_next = xfer_cnt_reg + CNT_ONE;
            end
            tsq_pkg::ST_XDRAIN:
            begin
                strobe_next             = 1'b1;
                rsp_next.status         = tsq_pkg::STATUS_OK;
                rsp_next.dequeued_value = '0;
                rsp_next.now_empty      = 1'b0;
                if (cmd_reg.mode == tsq_pkg::MODE_ENQ)
                begin
                    // pending push onto the emptied inbox
                    in_we        = 1'b1;
                    in_waddr     = '0;
                    in_wdata     = cmd_reg.enqueue_value;
                    in_cnt_next  = CNT_ONE;
                    out_cnt_next = in_cnt_reg;
                end
                else
                begin
                    // oldest word is the one just read, forwarded past the outbox
                    rsp_next.dequeued_value = in_rdata_reg;
                    rsp_next.now_empty      = (in_cnt_reg == CNT_ONE);
                    in_cnt_next             = CNT_ZERO;
                    out_cnt_next            = in_cnt_reg - CNT_ONE;
                end
            end
            tsq_pkg::ST_POP:
            begin
                strobe_next             = 1'b1;
                rsp_next.status         = tsq_pkg::STATUS_OK;
                rsp_next.dequeued_value = out_rdata_reg;
                rsp_next.now_empty      = (in_cnt_reg == CNT_ZERO) && (out_cnt_reg == CNT_ZERO);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsq_pkg::ST_IDLE;
            in_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            xfer_cnt_reg <= '0;
            wr_vld_reg   <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_cnt_reg   <= in_cnt_next;
            out_cnt_reg  <= out_cnt_next;
            xfer_cnt_reg <= xfer_cnt_next;
            wr_vld_reg   <= wr_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        rsp_reg     <= rsp_next;
        wr_addr_reg <= wr_addr_next;
    end

    // inbox memory
    always_ff @(posedge clk)
    begin
        if (in_we)
            inbox_mem[in_waddr] <= in_wdata;
        in_rdata_reg <= inbox_mem[in_raddr];
    end

    // outbox memory
    always_ff @(posedge clk)
    begin
        if (wr_vld_reg)
            outbox_mem[wr_addr_reg] <= in_rdata_reg;
        out_rdata_reg <= outbox_mem[out_raddr];
    end

    // ports
    assign busy   = (state_reg != tsq_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign result = rsp_reg;

endmodule

>>> hdl/tsq_checker.sv
// port-level checks of the two-stack queue, bound to the top level
`include "two_stack_queue_assert.svh"

module tsq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input tsq_pkg::tsq_cmd_t cmd,
    input logic              strobe,
    input tsq_pkg::tsq_rsp_t result
);

    // a refused beat carries no word
    `TSQ_ASSERT_NOW(a_refusal_no_word, strobe && result.status != tsq_pkg::STATUS_OK, result.dequeued_value == '0)

    // an empty refusal leaves the queue empty, a full refusal leaves it not empty
    `TSQ_ASSERT_NOW(a_empty_refusal, strobe && result.status == tsq_pkg::STATUS_EMPTY, result.now_empty)
    `TSQ_ASSERT_NOW(a_full_refusal, strobe && result.status == tsq_pkg::STATUS_FULL, !result.now_empty)

    // a finished move or pop delivers its beat as busy drops
    `TSQ_ASSERT_NOW(a_busy_end_beat, $fell(busy), strobe)

    // an accepted enqueue never reports empty on its result
    `TSQ_ASSERT_NEXT(a_enq_not_empty, start && !busy && cmd.mode == tsq_pkg::MODE_ENQ && !$past(busy), busy || (strobe && !result.now_empty))

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
);

>>> verif/tsq_scoreboard_pkg.sv
// scoreboard for the two-stack queue: behavioral prediction and result checking
package tsq_scoreboard_pkg;

    import tsq_pkg::*;

    class tsq_scoreboard;

        // mirror of the two stacks
        logic signed [WORD_W-1:0] inbox_words [DEPTH_DEFAULT];
        logic signed [WORD_W-1:0] outbox_words [DEPTH_DEFAULT];
        int inbox_fill;
        int outbox_fill;

        // results owed by the block, oldest first
        tsq_rsp_t owed_results[$];
        int mismatch_count;

        function new();
            inbox_fill = 0;
            outbox_fill = 0;
            mismatch_count = 0;
        endfunction

        // reverse the whole inbox onto the empty outbox
        function void move_inbox_across();
            for (int i = 0; i < inbox_fill; i++)
                outbox_words[i] = inbox_words[inbox_fill - 1 - i];
            outbox_fill = inbox_fill;
            inbox_fill = 0;
        endfunction

        // apply one operation to the mirror and return the result it yields
        function tsq_rsp_t predict_result(tsq_cmd_t c);
            tsq_rsp_t r;
            r.status = STATUS_OK;
            r.dequeued_value = '0;
            if (c.mode == MODE_ENQ)
            begin
                // full inbox: move across if the outbox is free, else refuse
                if (inbox_fill >= DEPTH_DEFAULT)
                begin
                    if (outbox_fill != 0)
                        r.status = STATUS_FULL;
                    else
                        move_inbox_across();
                end
                if (r.status == STATUS_OK)
                begin
                    inbox_words[inbox_fill] = c.enqueue_value;
                    inbox_fill++;
                end
            end
            else
            begin
                // empty outbox: refill from the inbox, or refuse when both are empty
                if (outbox_fill == 0)
                begin
                    if (inbox_fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                        move_inbox_across();
                end
                if (r.status == STATUS_OK)
                begin
                    outbox_fill--;
                    r.dequeued_value = outbox_words[outbox_fill];
                end
            end
            r.now_empty = (inbox_fill == 0 && outbox_fill == 0);
            return r;
        endfunction

        // accepted command beat
        function void note_command(tsq_cmd_t c);
            owed_results.push_back(predict_result(c));
        endfunction

        function void report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        endfunction

        // accepted result beat, compared against the oldest owed result
        function void check_result(tsq_rsp_t got);
            tsq_rsp_t want;
            if (owed_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %h", got);
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
                report("status", WORD_W'(want.status), WORD_W'(got.status));
            if (got.dequeued_value !== want.dequeued_value)
                report("dequeued_value", want.dequeued_value, got.dequeued_value);
            if (got.now_empty !== want.now_empty)
                report("now_empty", WORD_W'(want.now_empty), WORD_W'(got.now_empty));
        endfunction

    endclass

endpackage

>>> verif/tb_top.sv
// top-level testbench of the two-stack queue: stimulus, monitor and end of run
module tb_top;

    import tsq_pkg::*;
    import tsq_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 550;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    tsq_cmd_t cmd;
    logic     strobe;
    tsq_rsp_t result;

    tsq_scoreboard sb = new();

    two_stack_queue #(
        .DEPTH(DEPTH_DEFAULT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .strobe(strobe),
        .result(result)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // monitor: command beats feed the predictor, result beats are checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                sb.note_command(cmd);
            if (strobe)
                sb.check_result(result);
        end
    end

    function automatic tsq_cmd_t make_cmd(logic mode, logic [WORD_W-1:0] value);
        tsq_cmd_t c;
        c.mode = mode;
        c.enqueue_value = value;
        return c;
    endfunction

    // present one command and hold it until the block takes it; start stays high
    task automatic issue(tsq_cmd_t c);
        cmd = c;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // drop start for a number of cycles
    task automatic pause(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int enq_pct;
        int burst;
        int sent;
        int waited;
        logic [WORD_W-1:0] pattern [4];

        pattern[0] = 32'h5555_5555;
        pattern[1] = 32'hAAAA_AAAA;
        pattern[2] = 32'h0000_0000;
        pattern[3] = 32'hFFFF_FFFF;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: dequeue from an empty queue
        issue(make_cmd(MODE_DEQ, 32'h1234_5678));
        // directed: extreme words, then a dequeue that moves the inbox across
        issue(make_cmd(MODE_ENQ, 32'h8000_0000));
        issue(make_cmd(MODE_ENQ, 32'h7FFF_FFFF));
        pause(2);
        issue(make_cmd(MODE_DEQ, 32'hFFFF_FFFF));
        // directed: fill the inbox while the outbox still holds a word
        for (int i = 0; i < DEPTH_DEFAULT; i++)
            issue(make_cmd(MODE_ENQ, pattern[i % 4]));
        // directed: inbox full with outbox not empty is refused
        issue(make_cmd(MODE_ENQ, 32'hDEAD_BEEF));
        // directed: empty the outbox, then an enqueue on a full inbox moves it across
        issue(make_cmd(MODE_DEQ, 32'h0));
        issue(make_cmd(MODE_ENQ, 32'h0BAD_F00D));

        // random bursts, each leaning toward filling, toward draining, or toward neither
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 25;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(1, 100) <= enq_pct)
                    issue(make_cmd(MODE_ENQ, pick_word()));
                else
                    issue(make_cmd(MODE_DEQ, $urandom));
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 6));
        end

        // drain the owed results, then let the block settle
        start = 1'b0;
        waited = 0;
        while (sb.owed_results.size() != 0 && waited < 2000) begin
            @(negedge clk);
            waited++;
        end
        repeat (DEPTH_DEFAULT + 8) @(negedge clk);

        if (sb.mismatch_count == 0 && sb.owed_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
